// ----- rtl/crtd_pkg.sv -----
// Package with the shared types and constants of the column RLE texture decoder.
package crtd_pkg;

  // Field widths of the channels.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RunW    = 7;
  localparam int unsigned HeightW = 16;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_RLE_MODE      = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_COLUMN_HEIGHT = 8'd1;

  // Mode codes; anything other than the transparent code acts as solid colour.
  localparam logic [ModeW-1:0] MODE_SOLID       = 2'd1;
  localparam logic [ModeW-1:0] MODE_TRANSPARENT = 2'd2;

  // Reset values of the registers.
  localparam logic [HeightW-1:0] HEIGHT_RESET = 16'd64;

  // Bit of a control byte that marks a repeated run.
  localparam int unsigned RUN_FLAG_BIT = 7;

  // Configuration seen by the decoder.
  typedef struct packed {
    logic [ModeW-1:0]   rle_mode;
    logic [HeightW-1:0] column_height;
  } cfg_t;

  // One run token.
  typedef struct packed {
    logic [ByteW-1:0] pixel;
    logic [RunW-1:0]  repeat_res;
    logic             column_end;
    logic             overrun;
  } token_t;

endpackage

// ----- rtl/crtd_ifs.sv -----
// Valid/ready channel interfaces of the column RLE texture decoder.

// Compressed byte stream, one byte per item.
interface crtd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [crtd_pkg::ByteW-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

// Run tokens, one token per item.
interface crtd_tok_if;
  logic                      valid;
  logic                      ready;
  logic [crtd_pkg::ByteW-1:0] pixel;
  logic [crtd_pkg::RunW-1:0]  repeat_res;
  logic                      column_end;
  logic                      overrun;

  modport source (output valid, output pixel, output repeat_res, output column_end,
                  output overrun, input ready);
  modport sink (input valid, input pixel, input repeat_res, input column_end,
                input overrun, output ready);
endinterface

// Configuration register writes.
interface crtd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [crtd_pkg::CfgIdxW-1:0] index;
  logic [crtd_pkg::CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/crtd_cfg_regs.sv -----
// Configuration registers of the column RLE texture decoder.
module crtd_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  crtd_cfg_if.sink       cfg_i,
  output crtd_pkg::cfg_t cfg_o
);
  import crtd_pkg::*;

  logic [ModeW-1:0]   rle_mode_q;
  logic [HeightW-1:0] column_height_q;
  logic               wr_en;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_mode_q      <= MODE_SOLID;
      column_height_q <= HEIGHT_RESET;
    end else if (wr_en) begin
      if (cfg_i.index == REG_RLE_MODE) begin
        rle_mode_q <= cfg_i.data[ModeW-1:0];
      end
      if (cfg_i.index == REG_COLUMN_HEIGHT) begin
        column_height_q <= cfg_i.data[HeightW-1:0];
      end
    end
  end

  assign cfg_o.rle_mode      = rle_mode_q;
  assign cfg_o.column_height = column_height_q;

endmodule

// ----- rtl/crtd_core.sv -----
// Decoder core: input register, column state, token logic and result register.
module crtd_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  crtd_pkg::cfg_t cfg_i,
  crtd_byte_if.sink      code_i,
  crtd_tok_if.source     tok_o
);
  import crtd_pkg::*;

  // Phase codes.
  localparam logic [1:0] PH_CTRL  = 2'd0;
  localparam logic [1:0] PH_COLOR = 2'd1;
  localparam logic [1:0] PH_LIT   = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  logic               in_vld_q;
  logic [ByteW-1:0]   in_byte_q;
  logic [1:0]         phase_q, phase_d;
  logic [RunW-1:0]    lit_q, lit_d;
  logic [RunW-1:0]    pend_q, pend_d;
  logic [HeightW-1:0] pix_left_q, pix_left_d;
  logic               out_vld_q;
  token_t             out_tok_q;

  logic               has_res;
  logic               advance;
  logic               in_take;
  logic [RunW-1:0]    lit_dec;
  logic [RunW-1:0]    run_n;
  logic [ByteW-1:0]   run_val;
  logic               run_extra;
  logic [HeightW-1:0] run_n_ext;
  logic [HeightW-1:0] height_now;
  logic               run_done;
  token_t             tok_d;

  // The stage moves on when it holds an item and its token, if any, has room.
  assign advance = in_vld_q && (!has_res || !out_vld_q || tok_o.ready);
  assign code_i.ready = !in_vld_q || advance;
  assign in_take = code_i.valid && code_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (code_i.ready) begin
      in_vld_q <= code_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= code_i.code_byte;
    end
  end

  // A column height of zero acts as one.
  assign height_now = (cfg_i.column_height == '0) ? HeightW'(1) : cfg_i.column_height;
  assign lit_dec    = lit_q - RunW'(1);

  // Select the run that this byte would emit.
  always_comb begin
    run_val   = in_byte_q;
    run_n     = RunW'(1);
    run_extra = 1'b0;
    unique case (phase_q)
      PH_CTRL: begin
        run_val = '0;
        run_n   = in_byte_q[RunW-1:0];
      end
      PH_COLOR: begin
        run_n = pend_q;
      end
      PH_LIT: begin
        run_extra = (lit_dec != '0);
      end
      PH_SKIP: begin
        run_n = RunW'(1);
      end
    endcase
  end

  // Clip the run to the pixels left in the column.
  assign run_n_ext = HeightW'(run_n);
  assign run_done  = (run_n_ext >= pix_left_q);

  always_comb begin
    tok_d.pixel      = run_val;
    tok_d.repeat_res = run_done ? pix_left_q[RunW-1:0] : run_n;
    tok_d.column_end = run_done;
    tok_d.overrun    = (run_n_ext > pix_left_q) || (run_done && run_extra);
  end

  // Next state and whether this byte emits a token.
  always_comb begin
    phase_d    = phase_q;
    lit_d      = lit_q;
    pend_d     = pend_q;
    pix_left_d = pix_left_q;
    has_res    = 1'b0;
    unique case (phase_q)
      PH_CTRL: begin
        if (in_byte_q[RUN_FLAG_BIT]) begin
          if (cfg_i.rle_mode == MODE_TRANSPARENT) begin
            has_res = (in_byte_q[RunW-1:0] != '0);
          end else begin
            pend_d  = in_byte_q[RunW-1:0];
            phase_d = PH_COLOR;
          end
        end else if (in_byte_q != '0) begin
          lit_d   = in_byte_q[RunW-1:0];
          phase_d = PH_LIT;
        end
      end
      PH_COLOR: begin
        phase_d = PH_CTRL;
        pend_d  = '0;
        has_res = (pend_q != '0);
      end
      PH_LIT: begin
        lit_d   = lit_dec;
        has_res = 1'b1;
        if (lit_dec == '0) begin
          phase_d = PH_CTRL;
        end else if (run_done) begin
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
        lit_d = lit_dec;
        if (lit_dec == '0) begin
          phase_d = PH_CTRL;
        end
      end
    endcase
    if (has_res) begin
      pix_left_d = run_done ? height_now : (pix_left_q - run_n_ext);
    end
  end

  // Column state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CTRL;
      lit_q      <= '0;
      pend_q     <= '0;
      pix_left_q <= HEIGHT_RESET;
    end else if (advance) begin
      phase_q    <= phase_d;
      lit_q      <= lit_d;
      pend_q     <= pend_d;
      pix_left_q <= pix_left_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && has_res) begin
      out_vld_q <= 1'b1;
    end else if (tok_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_res) begin
      out_tok_q <= tok_d;
    end
  end

  assign tok_o.valid      = out_vld_q;
  assign tok_o.pixel      = out_tok_q.pixel;
  assign tok_o.repeat_res = out_tok_q.repeat_res;
  assign tok_o.column_end = out_tok_q.column_end;
  assign tok_o.overrun    = out_tok_q.overrun;

  // The column always owes at least one pixel.
  a_pix_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_left_q != '0)
    else $error("pixels left reached zero");

  // Literal phases always have bytes still to take in.
  a_lit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LIT || phase_q == PH_SKIP) |-> lit_q != '0)
    else $error("literal phase with no bytes left");

  // A token never carries a zero repeat.
  a_repeat_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_tok_q.repeat_res != '0)
    else $error("token with zero repeat");

  // A clipped run always ends its column.
  a_overrun_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_tok_q.overrun) |-> out_tok_q.column_end)
    else $error("overrun token without column end");

  // A token produced by the stage shows up in the result register.
  a_token_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && has_res) |=> out_vld_q)
    else $error("token lost on its way to the result register");

endmodule

// ----- rtl/column_rle_texture_decoder.sv -----
// Top level of the column RLE texture decoder.
//
// The block turns a stream of run-length coded texture column bytes into run
// tokens. Bytes enter on code_i, one byte per item; tokens leave on tok_o with
// a pixel value, a repeat count, a column end flag and an overrun flag. A byte
// yields at most one token: skipped literal bytes and control bytes yield none,
// save repeated-run control bytes in transparent mode. Registers are written on
// cfg_i: index 0 is the run mode, index 1 the column height. Writes are always
// taken and should happen only while the block idles.
// A byte is taken into the input register, decoded in a single pass against
// the column state, and its token is loaded into the result register, from
// which it is offered on tok_o. One byte is taken in every cycle, unless a
// stalled token in the result register holds back a byte that yields a token;
// the rate is set by the column state update.
// When the receiver stalls, the token waits in the result register and the
// input register still takes one more byte; bytes that yield no token keep
// flowing. Reset empties both registers, starts a new column of 64 pixels in
// solid-colour mode and waits for a control byte.
module column_rle_texture_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  crtd_cfg_if.sink  cfg_i,
  crtd_byte_if.sink code_i,
  crtd_tok_if.source tok_o
);
  import crtd_pkg::*;

  cfg_t cfg;

  // Configuration registers.
  crtd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Decoder datapath.
  crtd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .code_i (code_i),
    .tok_o  (tok_o)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench for the column RLE texture decoder: directed byte table, then random column streams.
module tb;
  import crtd_pkg::*;

  localparam int unsigned RandomItems   = 1250;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned NumRows       = 37;
  localparam logic [ByteW-1:0] RunFlag  = 8'h80;

  typedef enum logic [1:0] {PS_CTRL, PS_COLOR, PS_LIT, PS_SKIP} parse_state_e;
  typedef enum logic [0:0] {ROW_BYTE, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_TOKEN} exp_kind_e;

  // One row of the directed table: a code byte or a register write.
  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDatW-1:0] value;
    exp_kind_e          chk;
    token_t             tok;
  } stim_row_t;

  logic clk;
  logic rst_n;

  crtd_cfg_if  cfg_if ();
  crtd_byte_if code_if ();
  crtd_tok_if  tok_if ();

  column_rle_texture_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .code_i (code_if),
    .tok_o  (tok_if)
  );

  // Decoder state as the testbench sees it.
  logic [ModeW-1:0]   mdl_mode;
  logic [HeightW-1:0] mdl_height;
  parse_state_e       ps;
  logic [RunW-1:0]    lit_left;
  logic [HeightW-1:0] pix_left;
  logic [RunW-1:0]    pend_run;

  token_t tokens_due[$];
  int     errors      = 0;
  int     items_sent  = 0;
  int     tokens_seen = 0;
  int     reg_writes  = 0;
  int     burst_left  = 0;
  int     idle_cycles = 0;
  bit     hold_req    = 1'b0;

  // Directed rows, each a code byte or a register write, walked from the reset state.
  stim_row_t directed_rows [NumRows] = '{
    '{ROW_BYTE, 8'd0, 16'h0080, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h0055, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h0083, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h00aa, EXP_TOKEN, '{8'haa, 7'd3, 1'b0, 1'b0}},
    '{ROW_BYTE, 8'd0, 16'h0002, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h0000, EXP_TOKEN, '{8'h00, 7'd1, 1'b0, 1'b0}},
    '{ROW_BYTE, 8'd0, 16'h00ff, EXP_TOKEN, '{8'hff, 7'd1, 1'b0, 1'b0}},
    '{ROW_BYTE, 8'd0, 16'h0000, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h00ff, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h0011, EXP_TOKEN, '{8'h11, 7'd59, 1'b1, 1'b1}},
    '{ROW_BYTE, 8'd0, 16'h00ff, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h007f, EXP_TOKEN, '{8'h7f, 7'd64, 1'b1, 1'b1}},
    '{ROW_REG,  REG_RLE_MODE, 16'(MODE_TRANSPARENT), EXP_NONE, '0},
    '{ROW_BYTE, 8'd0, 16'h0080, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h0085, EXP_TOKEN, '{8'h00, 7'd5, 1'b0, 1'b0}},
    '{ROW_REG,  REG_COLUMN_HEIGHT, 16'd3, EXP_NONE, '0},
    '{ROW_BYTE, 8'd0, 16'h00bb, EXP_TOKEN, '{8'h00, 7'd59, 1'b1, 1'b0}},
    '{ROW_BYTE, 8'd0, 16'h0004, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h0001, EXP_TOKEN, '{8'h01, 7'd1, 1'b0, 1'b0}},
    '{ROW_BYTE, 8'd0, 16'h0002, EXP_TOKEN, '{8'h02, 7'd1, 1'b0, 1'b0}},
    '{ROW_BYTE, 8'd0, 16'h0003, EXP_TOKEN, '{8'h03, 7'd1, 1'b1, 1'b1}},
    '{ROW_BYTE, 8'd0, 16'h00fe, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h0081, EXP_TOKEN, '{8'h00, 7'd1, 1'b0, 1'b0}},
    '{ROW_BYTE, 8'd0, 16'h00ff, EXP_TOKEN, '{8'h00, 7'd2, 1'b1, 1'b1}},
    '{ROW_REG,  REG_COLUMN_HEIGHT, 16'd0, EXP_NONE, '0},
    '{ROW_BYTE, 8'd0, 16'h0083, EXP_TOKEN, '{8'h00, 7'd3, 1'b1, 1'b0}},
    '{ROW_BYTE, 8'd0, 16'h0081, EXP_TOKEN, '{8'h00, 7'd1, 1'b1, 1'b0}},
    '{ROW_REG,  REG_RLE_MODE, 16'd3, EXP_NONE, '0},
    '{ROW_BYTE, 8'd0, 16'h0082, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h007e, EXP_TOKEN, '{8'h7e, 7'd1, 1'b1, 1'b1}},
    '{ROW_REG,  8'd2, 16'hffff, EXP_NONE, '0},
    '{ROW_REG,  REG_COLUMN_HEIGHT, 16'hffff, EXP_NONE, '0},
    '{ROW_REG,  REG_RLE_MODE, 16'd0, EXP_NONE, '0},
    '{ROW_BYTE, 8'd0, 16'h00ff, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h005a, EXP_MODEL, '0},
    '{ROW_BYTE, 8'd0, 16'h00ff, EXP_NONE,  '0},
    '{ROW_BYTE, 8'd0, 16'h00c3, EXP_MODEL, '0}
  };

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Emits a run of n pixels clipped to what the column still owes.
  function automatic token_t clip_run(input logic [ByteW-1:0] value, input logic [RunW-1:0] n,
                                      input bit extra);
    logic [HeightW-1:0] take;
    token_t t;
    take = ({9'd0, n} < pix_left) ? {9'd0, n} : pix_left;
    t.pixel      = value;
    t.repeat_res = take[RunW-1:0];
    t.column_end = (take == pix_left);
    t.overrun    = ({9'd0, n} > pix_left) || (t.column_end && extra);
    pix_left = pix_left - take;
    if (t.column_end) begin
      pix_left = (mdl_height == '0) ? 16'd1 : mdl_height;
    end
    return t;
  endfunction

  // Advances the column parser by one code byte and returns the token it yields.
  task automatic decode_byte(input logic [ByteW-1:0] b, output bit emits, output token_t t);
    emits = 1'b0;
    t = '0;
    case (ps)
      PS_CTRL: begin
        if (b[RUN_FLAG_BIT]) begin
          if (mdl_mode == MODE_TRANSPARENT) begin
            if (b[RunW-1:0] != '0) begin
              emits = 1'b1;
              t = clip_run(8'd0, b[RunW-1:0], 1'b0);
            end
          end else begin
            pend_run = b[RunW-1:0];
            ps = PS_COLOR;
          end
        end else if (b != '0) begin
          lit_left = b[RunW-1:0];
          ps = PS_LIT;
        end
      end
      PS_COLOR: begin
        ps = PS_CTRL;
        if (pend_run != '0) begin
          emits = 1'b1;
          t = clip_run(b, pend_run, 1'b0);
          pend_run = '0;
        end
      end
      PS_LIT: begin
        lit_left = lit_left - 1'b1;
        emits = 1'b1;
        t = clip_run(b, 7'd1, lit_left != '0);
        if (lit_left == '0) begin
          ps = PS_CTRL;
        end else if (t.column_end) begin
          ps = PS_SKIP;
        end
      end
      default: begin
        lit_left = lit_left - 1'b1;
        if (lit_left == '0) begin
          ps = PS_CTRL;
        end
      end
    endcase
  endtask

  // Offers one code byte in the current burst and records what it should yield.
  task automatic push_byte(input logic [ByteW-1:0] b, input exp_kind_e chk, input token_t typed);
    int     gap;
    bit     emits;
    token_t t;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        code_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    code_if.valid     <= 1'b1;
    code_if.code_byte <= b;
    do @(posedge clk); while (!(code_if.valid && code_if.ready));
    decode_byte(b, emits, t);
    case (chk)
      EXP_MODEL: if (emits) tokens_due = {tokens_due, t};
      EXP_TOKEN: tokens_due = {tokens_due, typed};
      default: ;
    endcase
    items_sent++;
  endtask

  // Stops the byte stream and waits until the decoder has gone quiet.
  task automatic wait_idle();
    code_if.valid <= 1'b0;
    burst_left = 0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes one register in a single handshake.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    if (idx == REG_RLE_MODE) begin
      mdl_mode = val[ModeW-1:0];
    end else if (idx == REG_COLUMN_HEIGHT) begin
      mdl_height = val;
    end
    reg_writes++;
  endtask

  task automatic report_field(input string name, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  // Compares each accepted token with the oldest one due.
  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (rst_n && tok_if.valid && tok_if.ready) begin
      got = {tok_if.pixel, tok_if.repeat_res, tok_if.column_end, tok_if.overrun};
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t: token with none due: expected nothing, actual pixel %0d repeat %0d",
                 $time, got.pixel, got.repeat_res);
      end else begin
        want = tokens_due.pop_front();
        if (got.pixel != want.pixel) report_field("pixel", want.pixel, got.pixel);
        if (got.repeat_res != want.repeat_res) begin
          report_field("repeat", want.repeat_res, got.repeat_res);
        end
        if (got.column_end != want.column_end) begin
          report_field("column_end", want.column_end, got.column_end);
        end
        if (got.overrun != want.overrun) report_field("overrun", want.overrun, got.overrun);
      end
    end
  end

  // Ends the run when no item has moved on any channel for too long.
  always @(posedge clk) begin
    if ((code_if.valid && code_if.ready) || (tok_if.valid && tok_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Token receiver: randomly chosen stall styles, plus one long hold-off.
  initial begin : tok_receiver
    int style;
    int cyc;
    style = 0;
    cyc = 0;
    tok_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        tok_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if (cyc % 48 == 0) begin
        style = $urandom_range(0, 3);
      end
      cyc++;
      case (style)
        0: tok_if.ready <= 1'b1;
        1: tok_if.ready <= ($urandom_range(0, 1) == 1);
        2: tok_if.ready <= ($urandom_range(0, 3) == 0);
        default: tok_if.ready <= ((cyc % 7) < 3);
      endcase
    end
  end

  // Reset, directed table, then random phases with fresh register settings.
  initial begin : stimulus
    int r;
    int n;
    int quota;
    bit spare_write;
    rst_n = 1'b0;
    code_if.valid = 1'b0;
    code_if.code_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    mdl_mode   = MODE_SOLID;
    mdl_height = HEIGHT_RESET;
    ps         = PS_CTRL;
    lit_left   = '0;
    pix_left   = HEIGHT_RESET;
    pend_run   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        push_byte(directed_rows[i].value[ByteW-1:0], directed_rows[i].chk, directed_rows[i].tok);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      // Mostly the two real modes, now and then an odd value.
      r = $urandom_range(0, 19);
      write_reg(REG_RLE_MODE, (r < 8) ? 16'(MODE_SOLID) :
                              (r < 16) ? 16'(MODE_TRANSPARENT) : 16'($urandom_range(0, 3)));
      // Short columns dominate so that column ends and clipping happen often.
      r = $urandom_range(0, 19);
      write_reg(REG_COLUMN_HEIGHT, (r == 0) ? 16'd1 : (r == 1) ? 16'hffff : (r == 2) ? 16'd0 :
                                   (r < 6) ? 16'($urandom_range(100, 600)) :
                                   16'($urandom_range(1, 80)));
      spare_write = ($urandom_range(0, 4) == 0);
      if (spare_write) begin
        write_reg(8'($urandom_range(2, 255)), 16'($urandom));
      end
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      quota = items_sent + RandomItems / NumPhases;
      while (items_sent < quota) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          // Repeated run, with its colour byte unless the mode is transparent.
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16);
          push_byte(RunFlag | 8'(n), EXP_MODEL, '0);
          if (mdl_mode != MODE_TRANSPARENT) begin
            push_byte(8'($urandom), EXP_MODEL, '0);
          end
        end else if (r < 80) begin
          // Literal run of random bytes, rarely empty or long.
          r = $urandom_range(0, 19);
          n = (r == 0) ? 0 : (r == 1) ? $urandom_range(20, 127) : $urandom_range(1, 6);
          push_byte(8'(n), EXP_MODEL, '0);
          repeat (n) push_byte(8'($urandom), EXP_MODEL, '0);
        end else begin
          // Stray byte that may knock the stream out of step.
          push_byte(8'($urandom), EXP_MODEL, '0);
        end
      end
    end

    wait_idle();
    $display("Decoded %0d code bytes into %0d checked run tokens across %0d register writes,",
             items_sent, tokens_seen, reg_writes);
    $display("with both run modes, clipped runs and literals, and one long output hold-off.");
    if (errors == 0 && tokens_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/crtd_pkg.sv
rtl/crtd_ifs.sv
rtl/crtd_cfg_regs.sv
rtl/crtd_core.sv
rtl/column_rle_texture_decoder.sv
sim/tb.sv
